### rtl/cgns_pkg.sv
// Shared types and constants for the clocked gate note sampler.
`timescale 1ns / 1ps
`default_nettype none
package cgns_pkg;

    localparam int PERIOD_BITS = 24;
    localparam int LEVEL_W     = 15;
    localparam int RAND_W      = 16;
    localparam int PROB_W      = 17;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic signed [LEVEL_W-1:0] VOLT_THRESH = 15'sd2400;
    localparam logic signed [LEVEL_W-1:0] TEN_VOLTS   = 15'sd12000;
    localparam logic signed [LEVEL_W:0]   FULL_WIDTH  = 16'sd12000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 15'sd16383;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = -15'sd16384;
    localparam logic [PROB_W-1:0]         PROB_ALWAYS = 17'h10000;

    localparam logic [1:0] QM_NONE = 2'd0;
    localparam logic [1:0] QM_VOLT = 2'd1;

    localparam logic [15:0] VOLT_STEP  = 16'd1200;
    localparam logic [14:0] VOLT_HALF  = 15'd600;
    localparam logic [15:0] VOLT_RECIP = 16'd55925;
    localparam logic [15:0] SEMI_STEP  = 16'd100;
    localparam logic [14:0] SEMI_HALF  = 15'd50;
    localparam logic [15:0] SEMI_RECIP = 16'd41944;
    localparam int          VOLT_SHIFT = 26;
    localparam int          SEMI_SHIFT = 22;
    localparam int          QUOT_W     = 9;

    typedef enum logic [1:0] {
        REG_PATCHED = 2'd0,
        REG_PROB    = 2'd1,
        REG_TRACK   = 2'd2,
        REG_QUANT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] clock_level;
        logic signed [LEVEL_W-1:0] trigger_level;
        logic signed [LEVEL_W-1:0] width_level;
        logic signed [LEVEL_W-1:0] note_level;
        logic [RAND_W-1:0]         random_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        patched_mask;
        logic [PROB_W-1:0] probability;
        logic              track_mode;
        logic [1:0]        quant_mode;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/cgns_in_if.sv
// Input channel interface: valid/ready handshake with the sample fields.
`timescale 1ns / 1ps
`default_nettype none
interface cgns_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [cgns_pkg::LEVEL_W-1:0] clock_level;
    logic signed [cgns_pkg::LEVEL_W-1:0] trigger_level;
    logic signed [cgns_pkg::LEVEL_W-1:0] width_level;
    logic signed [cgns_pkg::LEVEL_W-1:0] note_level;
    logic [cgns_pkg::RAND_W-1:0]         random_value;

    modport source (
        output valid, clock_level, trigger_level, width_level, note_level, random_value,
        input  ready
    );
    modport sink (
        input  valid, clock_level, trigger_level, width_level, note_level, random_value,
        output ready
    );
endinterface
`default_nettype wire

### rtl/cgns_out_if.sv
// Output channel interface: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface cgns_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cgns_pkg::LEVEL_W-1:0] main_level;
    logic                                clock_gate;

    modport source (
        output valid, main_level, clock_gate,
        input  ready
    );
    modport sink (
        input  valid, main_level, clock_gate,
        output ready
    );
endinterface
`default_nettype wire

### rtl/cgns_core.sv
// Edge detection, period averaging, pulse timing and held level state.
`timescale 1ns / 1ps
`default_nettype none
module cgns_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_acc,
    input  wire cgns_pkg::t_in_item                  i_item,
    input  wire cgns_pkg::t_cfg                      i_cfg,
    output logic signed [cgns_pkg::LEVEL_W-1:0]      o_held,
    output logic                                     o_gate
);

    localparam int PB = cgns_pkg::PERIOD_BITS;
    localparam int LW = cgns_pkg::LEVEL_W;

    logic                 r_clock_was_high, n_clock_was_high;
    logic [PB-1:0]        r_ticks, n_ticks;
    logic [PB-1:0]        r_avg, n_avg;
    logic signed [LW-1:0] r_width, n_width;
    logic signed [LW-1:0] r_held, n_held;
    logic                 r_gate, n_gate;

    logic signed [LW-1:0] w_clk, w_trg, w_wid, w_note, w_h0;
    logic [cgns_pkg::RAND_W-1:0] w_rnd;
    logic                 p_clk, p_trg, p_wid, p_note, p_prob;
    logic                 w_high, w_rise, w_fall, w_end, w_pass;
    logic [PB-1:0]        w_tick_inc;
    logic [PB:0]          w_sum;
    logic signed [PB+LW:0] w_lhs, w_rhs;

    always_comb begin
        w_clk  = i_item.clock_level;
        w_trg  = i_item.trigger_level;
        w_wid  = i_item.width_level;
        w_note = i_item.note_level;
        w_rnd  = i_item.random_value;
        p_clk  = i_cfg.patched_mask[0];
        p_trg  = i_cfg.patched_mask[1];
        p_wid  = i_cfg.patched_mask[2];
        p_note = i_cfg.patched_mask[3];
        p_prob = i_cfg.probability < cgns_pkg::PROB_ALWAYS;

        w_high     = w_clk > cgns_pkg::VOLT_THRESH;
        w_tick_inc = (r_ticks == {PB{1'b1}}) ? r_ticks : r_ticks + 1'b1;
        w_rise     = p_clk && w_high && !r_clock_was_high;
        w_fall     = p_clk && !w_high && r_clock_was_high;
        w_sum      = {1'b0, r_avg} + {1'b0, w_tick_inc};

        n_clock_was_high = p_clk ? w_high : r_clock_was_high;
        n_ticks = p_clk ? (w_rise ? '0 : w_tick_inc) : r_ticks;
        n_avg   = w_rise ? w_sum[PB:1] : r_avg;
        n_width = w_rise ? w_wid : r_width;

        w_lhs = (PB+LW+1)'(r_width) * (PB+LW+1)'($signed({1'b0, r_avg}));
        w_rhs = (PB+LW+1)'($signed({1'b0, n_ticks})) * (PB+LW+1)'(cgns_pkg::FULL_WIDTH);
        w_end = p_wid && (w_lhs < w_rhs);

        w_pass = (!p_trg || (w_trg > cgns_pkg::VOLT_THRESH)) &&
                 (!p_prob || (i_cfg.probability > {1'b0, w_rnd}));

        w_h0 = w_end ? '0 : r_held;
        if (w_rise) begin
            n_held = w_pass ? (p_note ? w_note : cgns_pkg::TEN_VOLTS) : '0;
            n_gate = n_held > 15'sd0;
        end else begin
            n_held = (p_note && (w_h0 > 15'sd0) && !i_cfg.track_mode) ? w_note : w_h0;
            n_gate = w_fall ? 1'b0 : r_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_was_high <= 1'b0;
            r_ticks          <= '0;
            r_avg            <= '0;
            r_width          <= '0;
            r_held           <= '0;
            r_gate           <= 1'b0;
        end else if (i_acc) begin
            r_clock_was_high <= n_clock_was_high;
            r_ticks          <= n_ticks;
            r_avg            <= n_avg;
            r_width          <= n_width;
            r_held           <= n_held;
            r_gate           <= n_gate;
        end
    end

    assign o_held = r_held;
    assign o_gate = r_gate;

endmodule
`default_nettype wire

### rtl/cgns_quant.sv
// Two-stage rounding of the held level to volts or semitones, or raw pass-through when quant mode is none.
`timescale 1ns / 1ps
`default_nettype none
module cgns_quant (
    input  wire logic                                i_clk,
    input  wire logic                                i_ld2,
    input  wire logic                                i_ld3,
    input  wire logic [1:0]                          i_quant_mode,
    input  wire logic signed [cgns_pkg::LEVEL_W-1:0] i_held,
    input  wire logic                                i_gate,
    output logic signed [cgns_pkg::LEVEL_W-1:0]      o_main_level,
    output logic                                     o_clock_gate
);

    localparam int LW = cgns_pkg::LEVEL_W;
    localparam int QW = cgns_pkg::QUOT_W;

    logic                 w_neg, w_volt, w_none;
    logic [LW-1:0]        w_mag, w_x;
    logic [30:0]          w_prod;
    logic [QW-1:0]        w_quot;

    logic [QW-1:0]        r_quot;
    logic                 r_neg, r_volt, r_none, r_gate2;
    logic signed [LW-1:0] r_raw;

    logic [15:0]          w_qv;
    logic signed [LW-1:0] w_main;

    logic signed [LW-1:0] r_main;
    logic                 r_gate3;

    always_comb begin
        w_none = i_quant_mode == cgns_pkg::QM_NONE;
        w_volt = i_quant_mode == cgns_pkg::QM_VOLT;
        w_neg  = i_held < 15'sd0;
        w_mag  = w_neg ? LW'(-i_held) : LW'(i_held);
        if (w_volt) begin
            w_x    = w_mag + cgns_pkg::VOLT_HALF;
            w_prod = 31'(w_x) * 31'(cgns_pkg::VOLT_RECIP);
            w_quot = QW'(w_prod[30:cgns_pkg::VOLT_SHIFT]);
        end else begin
            w_x    = w_mag + cgns_pkg::SEMI_HALF;
            w_prod = 31'(w_x) * 31'(cgns_pkg::SEMI_RECIP);
            w_quot = QW'(w_prod[30:cgns_pkg::SEMI_SHIFT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld2) begin
            r_quot  <= w_quot;
            r_neg   <= w_neg;
            r_volt  <= w_volt;
            r_none  <= w_none;
            r_raw   <= i_held;
            r_gate2 <= i_gate;
        end
    end

    always_comb begin
        w_qv = 16'(r_quot) * (r_volt ? cgns_pkg::VOLT_STEP : cgns_pkg::SEMI_STEP);
        priority if (r_none) begin
            w_main = r_raw;
        end else if (r_neg) begin
            w_main = (w_qv > 16'd16384) ? cgns_pkg::LEVEL_MIN : -$signed(LW'(w_qv));
        end else begin
            w_main = (w_qv > 16'd16383) ? cgns_pkg::LEVEL_MAX : $signed(LW'(w_qv));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld3) begin
            r_main  <= w_main;
            r_gate3 <= r_gate2;
        end
    end

    assign o_main_level = r_main;
    assign o_clock_gate = r_gate3;

endmodule
`default_nettype wire

### rtl/clocked_gate_note_sampler_top.sv
// Top level of the clocked gate note sampler: handshake, registers, pipeline.
// Path: a result passes the core state registers, then the two quantizer registers, before o_out offers it.
// Throughput: one transaction per cycle unless o_out stalls; the state update loop adds no stall of its own.
// Output stalls back up through the three pipeline registers to i_in.ready.
// Reset (synchronous, active low): state cleared, registers to defaults, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
module clocked_gate_note_sampler_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    cgns_in_if.sink                                i_in,
    cgns_out_if.source                             o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cgns_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [cgns_pkg::PDATA_W-1:0]      pwdata,
    output logic [cgns_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    localparam int LW = cgns_pkg::LEVEL_W;

    cgns_pkg::t_cfg       r_cfg;
    cgns_pkg::t_reg_idx   w_idx;
    cgns_pkg::t_in_item   w_item;
    logic                 w_wr;

    logic                 r_v1, r_v2, r_v3;
    logic                 w_adv3, w_free2, w_free1, w_acc;
    logic signed [LW-1:0] w_held;
    logic                 w_gate;

    assign pready = 1'b1;
    assign w_idx  = cgns_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.patched_mask <= '0;
            r_cfg.probability  <= cgns_pkg::PROB_ALWAYS;
            r_cfg.track_mode   <= 1'b0;
            r_cfg.quant_mode   <= cgns_pkg::QM_NONE;
        end else if (w_wr) begin
            unique case (w_idx)
                cgns_pkg::REG_PATCHED: r_cfg.patched_mask <= pwdata[3:0];
                cgns_pkg::REG_PROB:    r_cfg.probability  <= pwdata[16:0];
                cgns_pkg::REG_TRACK:   r_cfg.track_mode   <= pwdata[0];
                cgns_pkg::REG_QUANT:   r_cfg.quant_mode   <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            cgns_pkg::REG_PATCHED: prdata = 32'(r_cfg.patched_mask);
            cgns_pkg::REG_PROB:    prdata = 32'(r_cfg.probability);
            cgns_pkg::REG_TRACK:   prdata = 32'(r_cfg.track_mode);
            cgns_pkg::REG_QUANT:   prdata = 32'(r_cfg.quant_mode);
        endcase
    end

    assign w_adv3  = !r_v3 || o_out.ready;
    assign w_free2 = !r_v2 || w_adv3;
    assign w_free1 = !r_v1 || w_free2;
    assign w_acc   = i_in.valid && w_free1;
    assign i_in.ready = w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_free1) r_v1 <= i_in.valid;
            if (w_free2) r_v2 <= r_v1;
            if (w_adv3)  r_v3 <= r_v2;
        end
    end

    always_comb begin
        w_item.clock_level   = i_in.clock_level;
        w_item.trigger_level = i_in.trigger_level;
        w_item.width_level   = i_in.width_level;
        w_item.note_level    = i_in.note_level;
        w_item.random_value  = i_in.random_value;
    end

    cgns_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_held  (w_held),
        .o_gate  (w_gate)
    );

    cgns_quant u_quant (
        .i_clk        (i_clk),
        .i_ld2        (w_free2),
        .i_ld3        (w_adv3),
        .i_quant_mode (r_cfg.quant_mode),
        .i_held       (w_held),
        .i_gate       (w_gate),
        .o_main_level (o_out.main_level),
        .o_clock_gate (o_out.clock_gate)
    );

    assign o_out.valid = r_v3;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_free2) |-> !i_in.ready)
        else $error("input taken while first stage is stalled");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v1)
        else $error("accepted transaction lost from first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
